@@ src/pngidat_pkg.sv @@
// ----------------------------------------------------------------------------
// pngidat_pkg
// Shared constants, types and CRC helpers for the PNG IDAT stored encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pngidat_pkg;

   localparam int MAX_WIDTH        = 16384;
   localparam int MAX_HEIGHT       = 65535;
   localparam int STORED_BLOCK_MAX = 65535;
   localparam int QUEUE_DEPTH      = 2;

   // raw row length 1 + 6 * MAX_WIDTH fits here
   localparam int RAW_W = $clog2(1 + 6 * MAX_WIDTH + 1);

   localparam logic [31:0] CRC_POLY  = 32'hedb88320;
   localparam logic [31:0] CRC_INIT  = 32'hffffffff;
   localparam logic [16:0] ADLER_MOD = 17'd65521;
   localparam logic [7:0]  ZLIB_CMF  = 8'h78;
   localparam logic [7:0]  ZLIB_FLG  = 8'h01;
   localparam logic [31:0] TYPE_IDAT = 32'h49444154;
   localparam logic [31:0] TYPE_IEND = 32'h49454e44;

   // CSR indexes
   localparam logic REG_PIXEL_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   typedef struct packed {
      logic [15:0] sample;
      logic        start_row;
      logic        first_row;
      logic        final_row;
      logic        end_row;
   } item_type;

   typedef struct packed {
      logic idle;
      logic busy;
   } back_status_type;

   // one entry of the reflected CRC-32 byte table
   function automatic logic [31:0] crc_table_f(input logic [7:0] idx);
      logic [31:0] v;
      v = {24'd0, idx};
      for (int k = 0; k < 8; k++) begin
         v = (v >> 1) ^ (CRC_POLY & {32{v[0]}});
      end
      return v;
   endfunction

   function automatic logic [31:0] crc_byte_f(input logic [31:0] crc, input logic [7:0] b);
      return (crc >> 8) ^ crc_table_f(crc[7:0] ^ b);
   endfunction

   function automatic logic [14:0] clamp_width_f(input logic [14:0] w);
      logic [14:0] r;
      r = w;
      if (w == 15'd0) r = 15'd1;
      else if (32'(w) > 32'(MAX_WIDTH)) r = 15'(MAX_WIDTH);
      return r;
   endfunction

   function automatic logic [15:0] clamp_height_f(input logic [15:0] h);
      logic [15:0] r;
      r = h;
      if (h == 16'd0) r = 16'd1;
      else if (32'(h) > 32'(MAX_HEIGHT)) r = 16'(MAX_HEIGHT);
      return r;
   endfunction

   function automatic logic [RAW_W-1:0] raw_len_f(input logic [14:0] w);
      return RAW_W'(32'(w) * 32'd6 + 32'd1);
   endfunction

endpackage

`default_nettype wire

@@ src/png_rgb16_idat_stored_encoder.sv @@
// ----------------------------------------------------------------------------
// png_rgb16_idat_stored_encoder
// 16-bit RGB samples in, PNG IDAT/IEND chunk bytes out (stored deflate).
// ----------------------------------------------------------------------------
//
//  channel | ports                               | beat
//  --------+-------------------------------------+-----------------------------
//  req     | req_push, req_full, req_sample      | one colour sample
//  rsp     | rsp_pop, rsp_empty, rsp_out_byte,   | one stream byte + run/image
//          | rsp_last_of_run, rsp_image_done     | markers
//  csr     | APB: psel/penable/pwrite/paddr/...  | pixel_width @0, height @4
//
// The back sequencer emits one byte per cycle unless its output register stalls
// it, so a mid-row sample gives 2 bytes; a row start adds 9 (length, type,
// filter byte; +2 first row) plus 5 per stored block header, a row end adds 4
// (+4 Adler, +12 IEND on the last row).
// Front and back are parted by a QUEUE_DEPTH-entry FIFO; the output register
// stalls the sequencer only while a byte waits unpopped.
// Synchronous active-high reset; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module png_rgb16_idat_stored_encoder #(
   parameter int QUEUE_DEPTH = pngidat_pkg::QUEUE_DEPTH
) (
   input  wire         clock,
   input  wire         reset,
   // samples in
   input  wire         req_push,
   output logic        req_full,
   input  wire  [15:0] req_sample,
   // bytes out
   output logic        rsp_empty,
   input  wire         rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_run,
   output logic        rsp_image_done,
   // register port
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [2:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [14:0] pixel_width_ff, pixel_width_in;
   logic [15:0] image_height_ff, image_height_in;
   logic        csr_write;
   logic        reg_sel;

   logic                         q_push, q_full, q_pop, q_valid;
   pngidat_pkg::item_type        push_item, pop_item;
   pngidat_pkg::back_status_type back_status;

   // ---- register port: byte-lane bits of paddr are ignored
   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      pixel_width_in  = pixel_width_ff;
      image_height_in = image_height_ff;
      if (csr_write) begin
         case (reg_sel)
            pngidat_pkg::REG_PIXEL_WIDTH:  pixel_width_in  = csr_pwdata[14:0];
            pngidat_pkg::REG_IMAGE_HEIGHT: image_height_in = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         pngidat_pkg::REG_PIXEL_WIDTH:  csr_prdata = {17'd0, pixel_width_ff};
         pngidat_pkg::REG_IMAGE_HEIGHT: csr_prdata = {16'd0, image_height_ff};
         default:                       csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_width_ff  <= 15'd1;
         image_height_ff <= 16'd1;
      end else begin
         pixel_width_ff  <= pixel_width_in;
         image_height_ff <= image_height_in;
      end
   end

   // ---- front: row bookkeeping and tagging
   pngidat_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_sample (req_sample),
      .q_full     (q_full),
      .cfg_width  (pixel_width_ff),
      .cfg_height (image_height_ff),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   assign req_full = q_full;

   // ---- decoupling FIFO
   pngidat_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_item  (pop_item)
   );

   // ---- back: byte sequencer with CRC and Adler
   pngidat_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg_width       (pixel_width_ff),
      .q_valid         (q_valid),
      .q_item          (pop_item),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_image_done  (rsp_image_done),
      .status          (back_status)
   );

`ifndef SYNTH
   // the image-done byte always closes a run
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_image_done) |-> rsp_last_of_run)
      else $error("image_done without last_of_run");

   // an idle sequencer picks up a queued beat at once
   a_no_stall_idle: assert property (@(posedge clock) disable iff (reset)
      (back_status.idle && q_valid) |=> back_status.busy)
      else $error("sequencer idle with work queued");

   // nothing is shown right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result shown after reset");
`endif

endmodule

`default_nettype wire

@@ src/pngidat_front.sv @@
// ----------------------------------------------------------------------------
// pngidat_front
// Accepts samples, tracks row position and tags each beat with row flags.
// ----------------------------------------------------------------------------
`default_nettype none

module pngidat_front (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_push,
   input  wire  [15:0]            req_sample,
   input  wire                    q_full,
   input  wire  [14:0]            cfg_width,
   input  wire  [15:0]            cfg_height,
   output logic                   q_push,
   output pngidat_pkg::item_type  q_item
);

   logic [15:0] sample_in_row_ff, sample_in_row_in;
   logic [15:0] row_index_ff, row_index_in;
   logic [14:0] w;
   logic [15:0] h;
   logic [16:0] three_w;
   logic        row_end, row_final;

   assign w         = pngidat_pkg::clamp_width_f(cfg_width);
   assign h         = pngidat_pkg::clamp_height_f(cfg_height);
   assign three_w   = 17'({2'b00, w} * 17'd3);
   assign row_end   = ({1'b0, sample_in_row_ff} + 17'd1) >= three_w;
   assign row_final = ({1'b0, row_index_ff} + 17'd1) >= {1'b0, h};

   assign q_push = req_push & ~q_full;

   always_comb begin
      q_item.sample    = req_sample;
      q_item.start_row = sample_in_row_ff == 16'd0;
      q_item.first_row = row_index_ff == 16'd0;
      q_item.final_row = row_final;
      q_item.end_row   = row_end;
   end

   always_comb begin
      sample_in_row_in = sample_in_row_ff;
      row_index_in     = row_index_ff;
      if (q_push) begin
         if (row_end) begin
            sample_in_row_in = 16'd0;
            row_index_in     = row_final ? 16'd0 : row_index_ff + 16'd1;
         end else begin
            sample_in_row_in = sample_in_row_ff + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_in_row_ff <= 16'd0;
         row_index_ff     <= 16'd0;
      end else begin
         sample_in_row_ff <= sample_in_row_in;
         row_index_ff     <= row_index_in;
      end
   end

endmodule

`default_nettype wire

@@ src/pngidat_queue.sv @@
// ----------------------------------------------------------------------------
// pngidat_queue
// Short FIFO of tagged samples between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module pngidat_queue #(
   parameter int DEPTH = pngidat_pkg::QUEUE_DEPTH
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  pngidat_pkg::item_type  push_item,
   output logic                   full,
   input  wire                    pop,
   output logic                   valid,
   output pngidat_pkg::item_type  pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   pngidat_pkg::item_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = count_ff == CNT_W'(DEPTH);
   assign valid    = count_ff != '0;
   assign pop_item = mem_ff[rd_ptr_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ src/pngidat_back.sv @@
// ----------------------------------------------------------------------------
// pngidat_back
// Byte sequencer: chunk framing, stored block headers, Adler-32, CRC-32.
// ----------------------------------------------------------------------------
`default_nettype none

module pngidat_back (
   input  wire                           clock,
   input  wire                           reset,
   input  wire  [14:0]                   cfg_width,
   input  wire                           q_valid,
   input  pngidat_pkg::item_type         q_item,
   output logic                          q_pop,
   output logic                          rsp_empty,
   input  wire                           rsp_pop,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_last_of_run,
   output logic                          rsp_image_done,
   output pngidat_pkg::back_status_type  status
);

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_LEN   = 10'b0000000010,
      ST_TYPE  = 10'b0000000100,
      ST_ZHDR  = 10'b0000001000,
      ST_RAW   = 10'b0000010000,
      ST_ADLER = 10'b0000100000,
      ST_CRC   = 10'b0001000000,
      ST_ILEN  = 10'b0010000000,
      ST_ITYPE = 10'b0100000000,
      ST_ICRC  = 10'b1000000000
   } back_state_type;

   localparam int RW = pngidat_pkg::RAW_W;

   back_state_type        state_ff, state_in;
   pngidat_pkg::item_type cur_ff, cur_in;
   logic [2:0]            cnt_ff, cnt_in;
   logic [1:0]            raw_sel_ff, raw_sel_in;
   logic                  hdr_done_ff, hdr_done_in;
   logic [15:0]           fill_ff, fill_in;
   logic [RW-1:0]         pos_ff, pos_in;
   logic [31:0]           crc_ff, crc_in;
   logic [15:0]           alow_ff, alow_in, ahigh_ff, ahigh_in;
   logic                  out_valid_ff, out_valid_in;
   logic [7:0]            out_byte_ff, out_byte_in;
   logic                  out_last_ff, out_last_in, out_done_ff, out_done_in;

   logic          can_emit, emit, use_crc, crc_start, is_last, img_done, item_end;
   logic [7:0]    byte_v, data_v;
   logic [RW-1:0] raw, left;
   logic [15:0]   blen;
   logic          bfinal;
   logic [31:0]   len32;
   logic [16:0]   lo_sum, lo_n, hi_sum, hi_n, fill_plus;

   function automatic logic [7:0] be_byte_f(input logic [31:0] v, input logic [1:0] i);
      logic [7:0] r;
      case (i)
         2'd0:    r = v[31:24];
         2'd1:    r = v[23:16];
         2'd2:    r = v[15:8];
         default: r = v[7:0];
      endcase
      return r;
   endfunction

   assign raw   = pngidat_pkg::raw_len_f(pngidat_pkg::clamp_width_f(cfg_width));
   assign len32 = 32'(raw) + (cur_ff.first_row ? 32'd2 : 32'd0)
                + ((32'(raw) > 32'(pngidat_pkg::STORED_BLOCK_MAX)) ? 32'd10 : 32'd5)
                + (cur_ff.final_row ? 32'd4 : 32'd0);

   // bytes left in the row; no bytes left still gives LEN 1
   assign left   = (raw > pos_ff) ? raw - pos_ff : RW'(1);
   assign blen   = (32'(left) > 32'(pngidat_pkg::STORED_BLOCK_MAX))
                 ? 16'(pngidat_pkg::STORED_BLOCK_MAX) : 16'(left);
   assign bfinal = cur_ff.final_row && (32'(blen) == 32'(left));

   always_comb begin
      case (raw_sel_ff)
         2'd1:    data_v = cur_ff.sample[15:8];
         2'd2:    data_v = cur_ff.sample[7:0];
         default: data_v = 8'd0;
      endcase
   end

   // Adler sums stay below twice the modulus: one compare and subtract each
   assign lo_sum = {1'b0, alow_ff} + {9'd0, data_v};
   assign lo_n   = (lo_sum >= pngidat_pkg::ADLER_MOD) ? lo_sum - pngidat_pkg::ADLER_MOD : lo_sum;
   assign hi_sum = {1'b0, ahigh_ff} + lo_n;
   assign hi_n   = (hi_sum >= pngidat_pkg::ADLER_MOD) ? hi_sum - pngidat_pkg::ADLER_MOD : hi_sum;
   assign fill_plus = {1'b0, fill_ff} + 17'd1;

   assign can_emit = ~out_valid_ff | rsp_pop;

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      cnt_in      = cnt_ff;
      raw_sel_in  = raw_sel_ff;
      hdr_done_in = hdr_done_ff;
      fill_in     = fill_ff;
      pos_in      = pos_ff;
      alow_in     = alow_ff;
      ahigh_in    = ahigh_ff;
      q_pop       = 1'b0;
      emit        = 1'b0;
      use_crc     = 1'b0;
      crc_start   = 1'b0;
      is_last     = 1'b0;
      img_done    = 1'b0;
      item_end    = 1'b0;
      byte_v      = 8'd0;

      case (state_ff)
         ST_IDLE: begin
            item_end = 1'b1;
         end
         ST_LEN: begin
            if (can_emit) begin
               emit   = 1'b1;
               byte_v = be_byte_f(len32, cnt_ff[1:0]);
               cnt_in = cnt_ff + 3'd1;
               if (cnt_ff == 3'd3) begin
                  state_in = ST_TYPE;
                  cnt_in   = 3'd0;
               end
            end
         end
         ST_TYPE: begin
            if (can_emit) begin
               emit      = 1'b1;
               use_crc   = 1'b1;
               crc_start = cnt_ff == 3'd0;
               byte_v    = be_byte_f(pngidat_pkg::TYPE_IDAT, cnt_ff[1:0]);
               cnt_in    = cnt_ff + 3'd1;
               if (cnt_ff == 3'd3) begin
                  state_in = cur_ff.first_row ? ST_ZHDR : ST_RAW;
                  cnt_in   = 3'd0;
               end
            end
         end
         ST_ZHDR: begin
            if (can_emit) begin
               emit    = 1'b1;
               use_crc = 1'b1;
               byte_v  = (cnt_ff == 3'd0) ? pngidat_pkg::ZLIB_CMF : pngidat_pkg::ZLIB_FLG;
               cnt_in  = cnt_ff + 3'd1;
               if (cnt_ff == 3'd1) begin
                  state_in = ST_RAW;
                  cnt_in   = 3'd0;
               end
            end
         end
         ST_RAW: begin
            if (can_emit) begin
               emit    = 1'b1;
               use_crc = 1'b1;
               if (fill_ff == 16'd0 && !hdr_done_ff) begin
                  // stored block header: BFINAL, LEN, NLEN
                  case (cnt_ff)
                     3'd0:    byte_v = {7'd0, bfinal};
                     3'd1:    byte_v = blen[7:0];
                     3'd2:    byte_v = blen[15:8];
                     3'd3:    byte_v = ~blen[7:0];
                     default: byte_v = ~blen[15:8];
                  endcase
                  cnt_in = cnt_ff + 3'd1;
                  if (cnt_ff == 3'd4) begin
                     hdr_done_in = 1'b1;
                     cnt_in      = 3'd0;
                  end
               end else begin
                  byte_v      = data_v;
                  alow_in     = lo_n[15:0];
                  ahigh_in    = hi_n[15:0];
                  pos_in      = pos_ff + RW'(1);
                  fill_in     = (fill_plus >= 17'(pngidat_pkg::STORED_BLOCK_MAX))
                              ? 16'd0 : fill_plus[15:0];
                  hdr_done_in = 1'b0;
                  case (raw_sel_ff)
                     2'd0: raw_sel_in = 2'd1;
                     2'd1: raw_sel_in = 2'd2;
                     default: begin
                        if (cur_ff.end_row) begin
                           fill_in  = 16'd0;
                           pos_in   = '0;
                           state_in = cur_ff.final_row ? ST_ADLER : ST_CRC;
                           cnt_in   = 3'd0;
                        end else begin
                           is_last  = 1'b1;
                           item_end = 1'b1;
                        end
                     end
                  endcase
               end
            end
         end
         ST_ADLER: begin
            if (can_emit) begin
               emit    = 1'b1;
               use_crc = 1'b1;
               byte_v  = be_byte_f({ahigh_ff, alow_ff}, cnt_ff[1:0]);
               cnt_in  = cnt_ff + 3'd1;
               if (cnt_ff == 3'd3) begin
                  state_in = ST_CRC;
                  cnt_in   = 3'd0;
               end
            end
         end
         ST_CRC: begin
            if (can_emit) begin
               emit   = 1'b1;
               byte_v = be_byte_f(crc_ff ^ pngidat_pkg::CRC_INIT, cnt_ff[1:0]);
               cnt_in = cnt_ff + 3'd1;
               if (cnt_ff == 3'd3) begin
                  cnt_in = 3'd0;
                  if (cur_ff.final_row) begin
                     state_in = ST_ILEN;
                  end else begin
                     is_last  = 1'b1;
                     item_end = 1'b1;
                  end
               end
            end
         end
         ST_ILEN: begin
            if (can_emit) begin
               emit   = 1'b1;
               byte_v = 8'd0;
               cnt_in = cnt_ff + 3'd1;
               if (cnt_ff == 3'd3) begin
                  state_in = ST_ITYPE;
                  cnt_in   = 3'd0;
               end
            end
         end
         ST_ITYPE: begin
            if (can_emit) begin
               emit      = 1'b1;
               use_crc   = 1'b1;
               crc_start = cnt_ff == 3'd0;
               byte_v    = be_byte_f(pngidat_pkg::TYPE_IEND, cnt_ff[1:0]);
               cnt_in    = cnt_ff + 3'd1;
               if (cnt_ff == 3'd3) begin
                  state_in = ST_ICRC;
                  cnt_in   = 3'd0;
               end
            end
         end
         ST_ICRC: begin
            if (can_emit) begin
               emit   = 1'b1;
               byte_v = be_byte_f(crc_ff ^ pngidat_pkg::CRC_INIT, cnt_ff[1:0]);
               cnt_in = cnt_ff + 3'd1;
               if (cnt_ff == 3'd3) begin
                  cnt_in   = 3'd0;
                  is_last  = 1'b1;
                  img_done = 1'b1;
                  item_end = 1'b1;
                  alow_in  = 16'd1;
                  ahigh_in = 16'd0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // next beat starts straight away when one is queued
      if (item_end) begin
         if (q_valid) begin
            q_pop       = 1'b1;
            cur_in      = q_item;
            state_in    = q_item.start_row ? ST_LEN : ST_RAW;
            raw_sel_in  = q_item.start_row ? 2'd0 : 2'd1;
            cnt_in      = 3'd0;
            hdr_done_in = 1'b0;
         end else begin
            state_in = ST_IDLE;
         end
      end
   end

   always_comb begin
      crc_in = crc_ff;
      if (use_crc)
         crc_in = pngidat_pkg::crc_byte_f(crc_start ? pngidat_pkg::CRC_INIT : crc_ff, byte_v);
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_done_in  = out_done_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = byte_v;
         out_last_in  = is_last;
         out_done_in  = img_done;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= 3'd0;
         raw_sel_ff   <= 2'd0;
         hdr_done_ff  <= 1'b0;
         fill_ff      <= 16'd0;
         pos_ff       <= '0;
         crc_ff       <= pngidat_pkg::CRC_INIT;
         alow_ff      <= 16'd1;
         ahigh_ff     <= 16'd0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         raw_sel_ff   <= raw_sel_in;
         hdr_done_ff  <= hdr_done_in;
         fill_ff      <= fill_in;
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         alow_ff      <= alow_in;
         ahigh_ff     <= ahigh_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_done_ff <= out_done_in;
   end

   assign rsp_empty       = ~out_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_last_of_run = out_last_ff;
   assign rsp_image_done  = out_done_ff;
   assign status.idle     = state_ff == ST_IDLE;
   assign status.busy     = state_ff != ST_IDLE;

endmodule

`default_nettype wire
